// ----- design/insertion_sort_rotation_recorder_core_defines.svh -----
// assertion macros shared by the sorter rtl
`ifndef INSERTION_SORT_ROTATION_RECORDER_CORE_DEFINES_SVH
`define INSERTION_SORT_ROTATION_RECORDER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ISRR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isrr check failed");

// next-cycle implication
`define ISRR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isrr check failed");

`endif

// ----- design/isrr_pkg.sv -----
package isrr_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int DATA_WIDTH = 32;

  // fill count holds 0..MAX_ITEMS, cell index 0..MAX_ITEMS-1
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  // arithmetic width for positions before truncation to the result fields
  localparam int PW    = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [5:0] ROT_MAX = 6'd63;

  typedef struct packed {
    logic ins_en;    // a transfer inserts into the row this cycle
    logic occupied;  // cell index is below the fill count
    logic left_lt;   // left neighbor holds a value below the key
  } isrr_cell_ctrl_t;

endpackage

// ----- design/isrr_cell.sv -----
module isrr_cell
  import isrr_pkg::*;
(
  input  logic                  clk_i,
  input  isrr_cell_ctrl_t       ctrl_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [DATA_WIDTH-1:0] left_val_i,
  output logic [DATA_WIDTH-1:0] val_o,
  output logic                  lt_o,
  output logic                  bnd_o
);

  logic [DATA_WIDTH-1:0] val_q, val_d;

  assign lt_o  = ctrl_i.occupied && ($signed(val_q) < $signed(key_i));
  // first cell not below the key is where the new value lands
  assign bnd_o = !lt_o && ctrl_i.left_lt;
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins_en && !lt_o) begin
      val_d = ctrl_i.left_lt ? key_i : left_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- design/isrr_pos_enc.sv -----
module isrr_pos_enc
  import isrr_pkg::*;
(
  input  logic [MAX_ITEMS-1:0] onehot_i,
  output logic [IDX_W-1:0]     idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (onehot_i[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

endmodule

// ----- design/insertion_sort_rotation_recorder_core.sv -----
// online insertion sorter with rotation report
// input channel: value_i / last_i with in_valid_i, in_stall_o; a transfer
//   happens on a rising edge with valid high and stall low
// output channel: one result per input, out_valid_o with out_stall_i
// the sorted store is a row of cells; every cell compares its value with the
//   incoming key in parallel and either keeps, takes the key or takes its
//   left neighbor, so an insertion completes in the cycle of the transfer
// result path: the boundary is captured into the middle stage at the input
//   transfer, then position encoded into the output register
// throughput: one item per cycle while the receiver does not stall, limited
//   by the single cell row update
// a full store drops the item and flags overflow; last_i clears the count
//   and the rotation counter after the item
// reset: fill count, rotation counter and both valid flags clear; the cell
//   contents stay undefined and are never read beyond the fill count
// receiver stall: the output register holds, the middle stage holds, and
//   in_stall_o rises once both are occupied
`include "insertion_sort_rotation_recorder_core_defines.svh"

module insertion_sort_rotation_recorder_core
  import isrr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        moved_o,
  output logic [6:0]  left_pos_o,
  output logic [6:0]  right_pos_o,
  output logic [5:0]  shift_amount_o,
  output logic [5:0]  rotation_count_o,
  output logic        overflow_o,
  output logic        batch_end_o
);

  // control state
  logic [CNT_W-1:0] count_q, count_d;
  logic [5:0]       rot_q, rot_d;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;

  // middle stage payload
  logic [MAX_ITEMS-1:0] s1_bnd_q;
  logic [CNT_W-1:0]     s1_r_q;
  logic                 s1_moved_q;
  logic                 s1_ovf_q;
  logic                 s1_last_q;
  logic [5:0]           s1_rot_q;

  // output register payload
  logic       moved_q, ovf_q, last_q;
  logic [6:0] lpos_q, rpos_q;
  logic [5:0] shamt_q, rotc_q;

  logic                  in_acc, full, moved_now, out_ld, s1_adv;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]  lt, bnd, occ;
  logic [IDX_W-1:0]      l_idx;
  logic [PW-1:0]         l_w, r_w, lpos_w, rpos_w, shamt_w;

  // handshake: the output register frees the middle stage, which frees input
  assign out_ld     = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ld;
  assign in_stall_o = s1_valid_q && !out_ld;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign key  = value_i[DATA_WIDTH-1:0];
  assign full = (count_q == CNT_W'(MAX_ITEMS));

  // cell row
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isrr_cell_ctrl_t ctrl;
    assign occ[i]        = (CNT_W'(i) < count_q);
    assign ctrl.ins_en   = in_acc && !full;
    assign ctrl.occupied = occ[i];
    if (i == 0) begin : g_head
      assign ctrl.left_lt = 1'b1;
      isrr_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .key_i      (key),
        .left_val_i (key),
        .val_o      (cell_val[i]),
        .lt_o       (lt[i]),
        .bnd_o      (bnd[i])
      );
    end else begin : g_body
      assign ctrl.left_lt = lt[i-1];
      isrr_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .key_i      (key),
        .left_val_i (cell_val[i-1]),
        .val_o      (cell_val[i]),
        .lt_o       (lt[i]),
        .bnd_o      (bnd[i])
      );
    end
  end

  // a stored element not below the key means the tail has to move
  assign moved_now = |(occ & ~lt);

  // fill count and rotation counter
  always_comb begin
    count_d = count_q;
    rot_d   = rot_q;
    if (in_acc) begin
      if (!full) begin
        count_d = count_q + CNT_W'(1);
        if (moved_now && (rot_q != ROT_MAX)) begin
          rot_d = rot_q + 6'd1;
        end
      end
      if (last_i) begin
        count_d = '0;
        rot_d   = '0;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_ld ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rot_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rot_q       <= rot_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture the landing boundary and the item flags
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_bnd_q   <= bnd;
      s1_r_q     <= count_q;
      s1_moved_q <= moved_now && !full;
      s1_ovf_q   <= full;
      s1_last_q  <= last_i;
      // counter value including this item, before any batch clear
      s1_rot_q   <= (!full && moved_now && (rot_q != ROT_MAX)) ? rot_q + 6'd1 : rot_q;
    end
  end

  // boundary one-hot to landing index
  isrr_pos_enc u_pos_enc (
    .onehot_i (s1_bnd_q),
    .idx_o    (l_idx)
  );

  assign l_w     = PW'(l_idx);
  assign r_w     = PW'(s1_r_q);
  assign lpos_w  = l_w + PW'(1);
  assign rpos_w  = r_w + PW'(1);
  assign shamt_w = r_w - l_w;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      moved_q <= s1_moved_q;
      lpos_q  <= s1_moved_q ? lpos_w[6:0] : 7'd0;
      rpos_q  <= s1_moved_q ? rpos_w[6:0] : 7'd0;
      shamt_q <= s1_moved_q ? shamt_w[5:0] : 6'd0;
      rotc_q  <= s1_rot_q;
      ovf_q   <= s1_ovf_q;
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign moved_o          = moved_q;
  assign left_pos_o       = lpos_q;
  assign right_pos_o      = rpos_q;
  assign shift_amount_o   = shamt_q;
  assign rotation_count_o = rotc_q;
  assign overflow_o       = ovf_q;
  assign batch_end_o      = last_q;

  // checks
  `ISRR_ASSERT_NOW(a_bnd_onehot, in_acc && !full, $onehot(bnd))
  `ISRR_ASSERT_NOW(a_moved_span, out_valid_q && moved_q, rpos_q > lpos_q)
  `ISRR_ASSERT_NOW(a_ovf_no_move, out_valid_q && ovf_q, !moved_q)
  `ISRR_ASSERT_NEXT(a_last_clears, in_acc && last_i, (count_q == '0) && (rot_q == '0))

endmodule
